FILE: design/asmc_pkg.sv
// ----------------------------------------------------------------------------
// asmc_pkg
// Shared types and constants of the anchor slot match classifier: verdict
// codes, register indexes and the per-slot check flags.
// ----------------------------------------------------------------------------
`default_nettype none

package asmc_pkg;

    // number of table slots looked at per scan
    localparam int SLOTS_DEFAULT = 8;

    // widths fixed by the item and register fields
    localparam int WORD_W    = 32;
    localparam int VERDICT_W = 3;
    localparam int INDEX_W   = 4;
    localparam int CFG_IDX_W = 2;

    // size in bytes of the A5 word that must fit in the partition
    localparam logic [WORD_W:0] A5_BYTES = (WORD_W + 1)'(4);
    // highest A5 address whose word ends at or below the 4 GiB limit
    localparam logic [WORD_W-1:0] A5_LAST = 32'hFFFF_FFFC;

    // slot index reported when no slot matched
    localparam logic signed [INDEX_W-1:0] SLOT_NONE = -4'sd1;

    // qualifier count saturates at this value
    localparam logic [1:0] QUAL_MANY = 2'd2;

    // verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_NOT_FOUND = 3'd1,
        VERDICT_MISMATCH  = 3'd2,
        VERDICT_AMBIGUOUS = 3'd3,
        VERDICT_STALE     = 3'd4
    } verdict_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE            = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_ROOT_PRESENT = 2'd3;

    // outcome of testing one slot
    typedef struct packed {
        logic qualify;
        logic reject;
    } slot_check_t;

endpackage

`default_nettype wire

FILE: design/asmc_slot_check.sv
// ----------------------------------------------------------------------------
// asmc_slot_check
// Tests one anchor slot against the partition: stamp consistency, A5 word
// inside the partition and, when enabled, stack base inside [base, top].
// ----------------------------------------------------------------------------
`default_nettype none

module asmc_slot_check (
    input  wire logic [asmc_pkg::WORD_W-1:0] partition_base,
    input  wire logic [asmc_pkg::WORD_W:0]   partition_top,
    input  wire logic                        size_zero,
    input  wire logic                        stack_root_present,
    input  wire logic [asmc_pkg::WORD_W-1:0] stamp_before,
    input  wire logic [asmc_pkg::WORD_W-1:0] stamp_after,
    input  wire logic [asmc_pkg::WORD_W-1:0] a5_value,
    input  wire logic [asmc_pkg::WORD_W-1:0] stack_base_value,
    output asmc_pkg::slot_check_t            check
);

    logic                        kept;
    logic                        a5_ok;
    logic                        stack_ok;
    logic [asmc_pkg::WORD_W:0]   a5_end;

    // slot is live when stamped and both stamp reads agree
    assign kept = (stamp_before != '0) && (stamp_before == stamp_after);

    // A5 word fully inside the partition, no wrap past 4 GiB
    assign a5_end = {1'b0, a5_value} + asmc_pkg::A5_BYTES;
    assign a5_ok  = !size_zero
                 && (a5_value >= partition_base)
                 && (a5_end <= partition_top)
                 && (a5_value <= asmc_pkg::A5_LAST);

    // stack base in the closed range, partition must not run past 4 GiB
    assign stack_ok = !size_zero
                   && !partition_top[asmc_pkg::WORD_W]
                   && (stack_base_value >= partition_base)
                   && ({1'b0, stack_base_value} <= partition_top);

    // qualify or reject flags
    always_comb
    begin
        check.qualify = kept && a5_ok && (!stack_root_present || stack_ok);
        check.reject  = kept && a5_ok && stack_root_present && !stack_ok;
    end

endmodule

`default_nettype wire

FILE: design/anchor_slot_match_classifier.sv
// ----------------------------------------------------------------------------
// anchor_slot_match_classifier
// Scans anchor slots one request per cycle, unless stalled, and reports the slot that belongs
// to the configured partition, with a verdict, on the last slot of a scan.
// ----------------------------------------------------------------------------
// a last-slot request is registered in the input stage, then in the result register
// throughput: one slot request per cycle unless stalled; the slot test is combinational
// a held result stalls a later last-slot request and those behind it; other slots flow on
// reset: scan state, configuration and valid flags clear asynchronously
`default_nettype none

module anchor_slot_match_classifier #(
    parameter int SLOTS = asmc_pkg::SLOTS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_write,
    input  wire logic [asmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [asmc_pkg::WORD_W-1:0]         cfg_data,
    // slot requests
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [asmc_pkg::WORD_W-1:0]         stamp_before,
    input  wire logic [asmc_pkg::WORD_W-1:0]         a5_value,
    input  wire logic [asmc_pkg::WORD_W-1:0]         window_list_root,
    input  wire logic [asmc_pkg::WORD_W-1:0]         menu_list_root,
    input  wire logic [asmc_pkg::WORD_W-1:0]         stack_base_value,
    input  wire logic [asmc_pkg::WORD_W-1:0]         stamp_after,
    input  wire logic [asmc_pkg::WORD_W-1:0]         current_ticks,
    input  wire logic                                last_slot,
    // scan results
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [asmc_pkg::VERDICT_W-1:0]           verdict,
    output logic signed [asmc_pkg::INDEX_W-1:0]      slot_index,
    output logic [asmc_pkg::WORD_W-1:0]              match_stamp,
    output logic [asmc_pkg::WORD_W-1:0]              match_age,
    output logic [asmc_pkg::WORD_W-1:0]              match_a5,
    output logic [asmc_pkg::WORD_W-1:0]              match_window_list,
    output logic [asmc_pkg::WORD_W-1:0]              match_menu_list,
    output logic [asmc_pkg::WORD_W-1:0]              match_stack_base
);

    localparam int W  = asmc_pkg::WORD_W;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int HW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // configuration registers
    logic [W-1:0] base_reg;
    logic [W-1:0] size_reg;
    logic [W-1:0] max_age_reg;
    logic         srp_reg;
    logic [W:0]   top_reg;
    logic         size_zero_reg;

    // input stage
    logic         s1_valid_reg;
    logic [W-1:0] s1_stamp_before_reg;
    logic [W-1:0] s1_a5_reg;
    logic [W-1:0] s1_window_reg;
    logic [W-1:0] s1_menu_reg;
    logic [W-1:0] s1_stack_reg;
    logic [W-1:0] s1_stamp_after_reg;
    logic [W-1:0] s1_ticks_reg;
    logic         s1_last_reg;

    // scan state
    logic [CW-1:0] slot_cnt_reg,   slot_cnt_next;
    logic [1:0]    qual_cnt_reg,   qual_cnt_next;
    logic          rejected_reg,   rejected_next;
    logic [HW-1:0] held_slot_reg,  held_slot_next;
    logic [W-1:0]  held_stamp_reg, held_stamp_next;
    logic [W-1:0]  held_age_reg,   held_age_next;
    logic [W-1:0]  held_a5_reg,    held_a5_next;
    logic [W-1:0]  held_win_reg,   held_win_next;
    logic [W-1:0]  held_menu_reg,  held_menu_next;
    logic [W-1:0]  held_stack_reg, held_stack_next;

    // result register
    logic                               out_valid_reg;
    asmc_pkg::verdict_t                 out_verdict_reg,  out_verdict_next;
    logic signed [asmc_pkg::INDEX_W-1:0] out_index_reg,   out_index_next;
    logic [W-1:0]                       out_stamp_reg,    out_stamp_next;
    logic [W-1:0]                       out_age_reg,      out_age_next;
    logic [W-1:0]                       out_a5_reg,       out_a5_next;
    logic [W-1:0]                       out_win_reg,      out_win_next;
    logic [W-1:0]                       out_menu_reg,     out_menu_next;
    logic [W-1:0]                       out_stack_reg,    out_stack_next;

    logic                  out_free;
    logic                  s1_advance;
    logic                  accept;
    logic [W-1:0]          stack_masked;
    logic [W-1:0]          new_age;
    logic                  scan_open;
    asmc_pkg::slot_check_t check;

    // ------------------------------------------------------------------
    // configuration, partition top kept precomputed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            size_reg      <= '0;
            max_age_reg   <= '0;
            srp_reg       <= 1'b0;
            top_reg       <= '0;
            size_zero_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                asmc_pkg::REG_PARTITION_BASE:
                begin
                    base_reg <= cfg_data;
                    top_reg  <= {1'b0, cfg_data} + {1'b0, size_reg};
                end
                asmc_pkg::REG_PARTITION_SIZE:
                begin
                    size_reg      <= cfg_data;
                    top_reg       <= {1'b0, base_reg} + {1'b0, cfg_data};
                    size_zero_reg <= (cfg_data == '0);
                end
                asmc_pkg::REG_MAX_AGE:
                begin
                    max_age_reg <= cfg_data;
                end
                asmc_pkg::REG_STACK_ROOT_PRESENT:
                begin
                    srp_reg <= cfg_data[0];
                end
                default:
                begin
                    srp_reg <= srp_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: only a last-slot request needs a free result register
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_stamp_before_reg <= stamp_before;
            s1_a5_reg           <= a5_value;
            s1_window_reg       <= window_list_root;
            s1_menu_reg         <= menu_list_root;
            s1_stack_reg        <= stack_base_value;
            s1_stamp_after_reg  <= stamp_after;
            s1_ticks_reg        <= current_ticks;
            s1_last_reg         <= last_slot;
        end
    end

    // ------------------------------------------------------------------
    // slot test
    asmc_slot_check u_check (
        .partition_base     (base_reg),
        .partition_top      (top_reg),
        .size_zero          (size_zero_reg),
        .stack_root_present (srp_reg),
        .stamp_before       (s1_stamp_before_reg),
        .stamp_after        (s1_stamp_after_reg),
        .a5_value           (s1_a5_reg),
        .stack_base_value   (stack_masked),
        .check              (check)
    );

    assign stack_masked = srp_reg ? s1_stack_reg : '0;
    assign new_age      = s1_ticks_reg - s1_stamp_before_reg;
    assign scan_open    = (slot_cnt_reg < CW'(SLOTS)) && (qual_cnt_reg < asmc_pkg::QUAL_MANY);

    // scan state update and result forming
    always_comb
    begin
        slot_cnt_next   = slot_cnt_reg;
        qual_cnt_next   = qual_cnt_reg;
        rejected_next   = rejected_reg;
        held_slot_next  = held_slot_reg;
        held_stamp_next = held_stamp_reg;
        held_age_next   = held_age_reg;
        held_a5_next    = held_a5_reg;
        held_win_next   = held_win_reg;
        held_menu_next  = held_menu_reg;
        held_stack_next = held_stack_reg;

        if (scan_open && check.reject)
        begin
            rejected_next = 1'b1;
        end
        if (scan_open && check.qualify)
        begin
            qual_cnt_next = qual_cnt_reg + 2'd1;
            // first qualifier is the one kept
            if (qual_cnt_reg == '0)
            begin
                held_slot_next  = slot_cnt_reg[HW-1:0];
                held_stamp_next = s1_stamp_before_reg;
                held_age_next   = new_age;
                held_a5_next    = s1_a5_reg;
                held_win_next   = s1_window_reg;
                held_menu_next  = s1_menu_reg;
                held_stack_next = stack_masked;
            end
        end
        if (slot_cnt_reg < CW'(SLOTS))
        begin
            slot_cnt_next = slot_cnt_reg + CW'(1);
        end

        // verdict from the updated scan state
        out_index_next = asmc_pkg::SLOT_NONE;
        out_stamp_next = '0;
        out_age_next   = '0;
        out_a5_next    = '0;
        out_win_next   = '0;
        out_menu_next  = '0;
        out_stack_next = '0;
        if (size_zero_reg)
        begin
            out_verdict_next = asmc_pkg::VERDICT_NOT_FOUND;
        end
        else if (qual_cnt_next >= asmc_pkg::QUAL_MANY)
        begin
            out_verdict_next = asmc_pkg::VERDICT_AMBIGUOUS;
        end
        else if (qual_cnt_next == 2'd1)
        begin
            out_verdict_next = ((max_age_reg != '0) && (held_age_next > max_age_reg))
                             ? asmc_pkg::VERDICT_STALE : asmc_pkg::VERDICT_OK;
            out_index_next = asmc_pkg::INDEX_W'(held_slot_next);
            out_stamp_next = held_stamp_next;
            out_age_next   = held_age_next;
            out_a5_next    = held_a5_next;
            out_win_next   = held_win_next;
            out_menu_next  = held_menu_next;
            out_stack_next = held_stack_next;
        end
        else
        begin
            out_verdict_next = rejected_next ? asmc_pkg::VERDICT_MISMATCH
                                             : asmc_pkg::VERDICT_NOT_FOUND;
        end
    end

    // scan state registers, cleared after the last slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg   <= '0;
            qual_cnt_reg   <= '0;
            rejected_reg   <= 1'b0;
            held_slot_reg  <= '0;
            held_stamp_reg <= '0;
            held_age_reg   <= '0;
            held_a5_reg    <= '0;
            held_win_reg   <= '0;
            held_menu_reg  <= '0;
            held_stack_reg <= '0;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                slot_cnt_reg   <= '0;
                qual_cnt_reg   <= '0;
                rejected_reg   <= 1'b0;
                held_slot_reg  <= '0;
                held_stamp_reg <= '0;
                held_age_reg   <= '0;
                held_a5_reg    <= '0;
                held_win_reg   <= '0;
                held_menu_reg  <= '0;
                held_stack_reg <= '0;
            end
            else
            begin
                slot_cnt_reg   <= slot_cnt_next;
                qual_cnt_reg   <= qual_cnt_next;
                rejected_reg   <= rejected_next;
                held_slot_reg  <= held_slot_next;
                held_stamp_reg <= held_stamp_next;
                held_age_reg   <= held_age_next;
                held_a5_reg    <= held_a5_next;
                held_win_reg   <= held_win_next;
                held_menu_reg  <= held_menu_next;
                held_stack_reg <= held_stack_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && s1_last_reg;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            out_verdict_reg <= out_verdict_next;
            out_index_reg   <= out_index_next;
            out_stamp_reg   <= out_stamp_next;
            out_age_reg     <= out_age_next;
            out_a5_reg      <= out_a5_next;
            out_win_reg     <= out_win_next;
            out_menu_reg    <= out_menu_next;
            out_stack_reg   <= out_stack_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign verdict           = out_verdict_reg;
    assign slot_index        = out_index_reg;
    assign match_stamp       = out_stamp_reg;
    assign match_age         = out_age_reg;
    assign match_a5          = out_a5_reg;
    assign match_window_list = out_win_reg;
    assign match_menu_list   = out_menu_reg;
    assign match_stack_base  = out_stack_reg;

endmodule

`default_nettype wire
